/* src/ccdt_pkg.sv */
// Package for the camera crop, decimate and threshold block.
// Field widths, crop window constants, register indexes and the shared structs.
// No dependencies.
`default_nettype none

package ccdt_pkg;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int ADDR_W   = 13;
    localparam int LINE_W   = 6;    // display line, 0..59
    localparam int COLH_W   = 7;    // display column, 0..79
    localparam int CFG_W    = 8;    // widest configuration register
    localparam int CFG_IDX_W = 2;

    // Default frame geometry
    localparam int FRAME_ROWS_DEF = 144;
    localparam int FRAME_COLS_DEF = 176;

    // Position compares run at this width; it covers counters up to 4095
    localparam int CMP_W = 12;

    // Crop window: odd rows 13..131, odd columns 9..167
    localparam logic [CMP_W-1:0] ROW_LO   = 12'd11;
    localparam logic [CMP_W-1:0] ROW_HI   = 12'd132;
    localparam logic [CMP_W-1:0] COL_LO   = 12'd7;
    localparam logic [CMP_W-1:0] COL_HI   = 12'd168;
    localparam logic [CMP_W-1:0] ROW_BASE = 12'd12;
    localparam logic [CMP_W-1:0] COL_BASE = 12'd9;
    localparam logic [CMP_W-1:0] LAST_ROW = 12'd13;
    localparam logic [CMP_W-1:0] LAST_COL = 12'd167;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 2'd0,
        CFG_LOW  = 2'd1,
        CFG_HIGH = 2'd2
    } cfg_idx_t;

    // Configuration register contents
    typedef struct packed {
        logic             mode;     // 1: threshold and track min/max
        logic [PIX_W-1:0] low;
        logic [PIX_W-1:0] high;
    } cfg_t;

    // Tracker stage to pixel stage
    typedef struct packed {
        logic              keep;    // pixel lies in the crop grid
        logic              clr;     // frame start seen on this beat
        logic              last;    // last kept pixel of the frame
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] addr;
    } trk_t;

endpackage

`default_nettype wire

/* src/ccdt_if.sv */
// Channel interfaces: camera pixel beats in, display write beats out.
// Depends on ccdt_pkg.
`default_nettype none

interface ccdt_pix_if;
    logic                       valid;
    logic                       ready;
    logic [ccdt_pkg::PIX_W-1:0] pixel_value;
    logic                       frame_start;
    logic                       line_start;

    modport source (output valid, output pixel_value, output frame_start,
                    output line_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start,
                    input line_start, output ready);
endinterface

interface ccdt_res_if;
    logic                        valid;
    logic                        ready;
    logic [ccdt_pkg::ADDR_W-1:0] write_addr;
    logic [ccdt_pkg::PIX_W-1:0]  write_data;
    logic [ccdt_pkg::PIX_W-1:0]  min_level;
    logic [ccdt_pkg::PIX_W-1:0]  max_level;
    logic                        frame_done;

    modport source (output valid, output write_addr, output write_data,
                    output min_level, output max_level, output frame_done,
                    input ready);
    modport sink   (input valid, input write_addr, input write_data,
                    input min_level, input max_level, input frame_done,
                    output ready);
endinterface

`default_nettype wire

/* src/ccdt_cfg.sv */
// Configuration registers: mode and threshold window, write only.
// Depends on ccdt_pkg.
`default_nettype none

module ccdt_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ccdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ccdt_pkg::CFG_W-1:0]     cfg_wdata,
    output ccdt_pkg::cfg_t                      cfg
);

    ccdt_pkg::cfg_t cfg_reg;
    ccdt_pkg::cfg_t cfg_next;

    // Address decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (ccdt_pkg::cfg_idx_t'(cfg_index))
                ccdt_pkg::CFG_MODE: cfg_next.mode = cfg_wdata[0];
                ccdt_pkg::CFG_LOW:  cfg_next.low  = cfg_wdata[ccdt_pkg::PIX_W-1:0];
                ccdt_pkg::CFG_HIGH: cfg_next.high = cfg_wdata[ccdt_pkg::PIX_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= 1'b1;
            cfg_reg.low  <= ccdt_pkg::PIX_BLACK;
            cfg_reg.high <= ccdt_pkg::PIX_WHITE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/ccdt_track.sv */
// Frame tracker: row/column counters, crop and decimation test, display address.
// Registers a beat for each accepted pixel that is kept or starts a frame. Depends on ccdt_pkg.
`default_nettype none

module ccdt_track #(
    parameter int FRAME_ROWS = ccdt_pkg::FRAME_ROWS_DEF,
    parameter int FRAME_COLS = ccdt_pkg::FRAME_COLS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ccdt_pix_if.sink        pixel,
    output logic            trk_valid,
    output ccdt_pkg::trk_t  trk,
    input  wire logic       trk_ready
);

    localparam int RW = $clog2(FRAME_ROWS);
    localparam int CW = $clog2(FRAME_COLS + 1);   // column saturates at FRAME_COLS
    localparam logic [RW-1:0] ROW_TOP  = RW'(FRAME_ROWS - 1);
    localparam logic [CW-1:0] COL_END  = CW'(FRAME_COLS);

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          over_reg, over_next;
    logic          valid_reg, valid_next;
    ccdt_pkg::trk_t trk_reg, trk_next;

    logic          accept;
    logic          live;
    logic          in_line;
    logic          keep;
    logic [RW-1:0] pos_row;
    logic [CW-1:0] pos_col;
    logic [ccdt_pkg::CMP_W-1:0] row_x, col_x, row_off, col_off;

    assign pixel.ready = !valid_reg || trk_ready;
    assign accept      = pixel.valid && pixel.ready;

    // Position of this pixel after frame and line starts
    always_comb
    begin
        pos_row   = row_reg;
        pos_col   = col_reg;
        live      = 1'b0;
        over_next = over_reg;
        if (pixel.frame_start)
        begin
            pos_row   = ROW_TOP;
            pos_col   = '0;
            over_next = 1'b0;
            live      = 1'b1;
        end
        else if (!over_reg)
        begin
            if (pixel.line_start && row_reg == '0)
            begin
                over_next = 1'b1;
            end
            else
            begin
                if (pixel.line_start)
                begin
                    pos_row = row_reg - 1'b1;
                    pos_col = '0;
                end
                live = 1'b1;
            end
        end
    end

    // Crop grid test and address
    always_comb
    begin
        in_line = live && (pos_col < COL_END);
        row_x   = {{(ccdt_pkg::CMP_W - RW){1'b0}}, pos_row};
        col_x   = {{(ccdt_pkg::CMP_W - CW){1'b0}}, pos_col};
        row_off = row_x - ccdt_pkg::ROW_BASE;
        col_off = col_x - ccdt_pkg::COL_BASE;
        keep    = in_line && row_x[0] && col_x[0]
                  && (row_x > ccdt_pkg::ROW_LO) && (row_x < ccdt_pkg::ROW_HI)
                  && (col_x > ccdt_pkg::COL_LO) && (col_x < ccdt_pkg::COL_HI);
    end

    // Counter and stage register update
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        trk_next = trk_reg;
        valid_next = (valid_reg && !trk_ready) ? 1'b1 : 1'b0;
        if (accept)
        begin
            if (live)
            begin
                row_next = pos_row;
                col_next = in_line ? pos_col + 1'b1 : pos_col;
            end
            valid_next     = pixel.frame_start || keep;
            trk_next.keep  = keep;
            trk_next.clr   = pixel.frame_start;
            trk_next.last  = (row_x == ccdt_pkg::LAST_ROW) && (col_x == ccdt_pkg::LAST_COL);
            trk_next.pixel = pixel.pixel_value;
            trk_next.addr  = {row_off[ccdt_pkg::LINE_W:1], col_off[ccdt_pkg::COLH_W:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= ROW_TOP;
            col_reg   <= '0;
            over_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            over_reg  <= accept ? over_next : over_reg;
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        trk_reg <= trk_next;
    end

    assign trk_valid = valid_reg;
    assign trk       = trk_reg;

endmodule

`default_nettype wire

/* src/ccdt_proc.sv */
// Pixel stage: threshold window, frame min/max, output register.
// Depends on ccdt_pkg and ccdt_res_if.
`default_nettype none

module ccdt_proc (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ccdt_pkg::cfg_t cfg,
    input  wire logic           trk_valid,
    input  wire ccdt_pkg::trk_t trk,
    output logic                trk_ready,
    ccdt_res_if.source          result
);

    logic [ccdt_pkg::PIX_W-1:0] min_reg, min_next;
    logic [ccdt_pkg::PIX_W-1:0] max_reg, max_next;
    logic                       out_valid_reg, out_valid_next;
    logic [ccdt_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ccdt_pkg::PIX_W-1:0] data_reg, data_next;
    logic                       done_reg, done_next;

    logic                       out_free;
    logic                       go;
    logic                       in_window;
    logic [ccdt_pkg::PIX_W-1:0] min_base, max_base;

    // Beats that write nothing never wait for the output slot
    assign out_free  = !out_valid_reg || result.ready;
    assign trk_ready = !trk.keep || out_free;
    assign go        = trk_valid && trk_ready;

    // Threshold and running statistics
    always_comb
    begin
        in_window = (trk.pixel >= cfg.low) && (trk.pixel <= cfg.high);
        min_base  = (trk.clr && cfg.mode) ? ccdt_pkg::PIX_WHITE : min_reg;
        max_base  = (trk.clr && cfg.mode) ? ccdt_pkg::PIX_BLACK : max_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        addr_next = addr_reg;
        data_next = data_reg;
        done_next = done_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (go)
        begin
            min_next = min_base;
            max_next = max_base;
            if (trk.keep)
            begin
                if (cfg.mode)
                begin
                    if (trk.pixel < min_base)
                        min_next = trk.pixel;
                    if (trk.pixel > max_base)
                        max_next = trk.pixel;
                    data_next = in_window ? ccdt_pkg::PIX_WHITE : ccdt_pkg::PIX_BLACK;
                end
                else
                begin
                    data_next = trk.pixel;
                end
                addr_next      = trk.addr;
                done_next      = trk.last;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= ccdt_pkg::PIX_WHITE;
            max_reg       <= ccdt_pkg::PIX_BLACK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        data_reg <= data_next;
        done_reg <= done_next;
    end

    // Levels show the statistics after the written pixel; they only move on a write
    logic [ccdt_pkg::PIX_W-1:0] min_out_reg, max_out_reg;

    always_ff @(posedge clk)
    begin
        if (go && trk.keep)
        begin
            min_out_reg <= min_next;
            max_out_reg <= max_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.write_addr = addr_reg;
    assign result.write_data = data_reg;
    assign result.min_level  = min_out_reg;
    assign result.max_level  = max_out_reg;
    assign result.frame_done = done_reg;

endmodule

`default_nettype wire

/* src/camera_crop_decimate_threshold_top.sv */
// Camera crop, decimate and threshold block: top level.
// Depends on ccdt_pkg, ccdt_if, ccdt_cfg, ccdt_track, ccdt_proc.
//
// Usage
//   pixel  : camera beats (pixel_value, frame_start, line_start), valid/ready.
//   result : display writes (write_addr, write_data, min_level, max_level,
//            frame_done), valid/ready. Only pixels on odd rows 13..131 and odd
//            columns 9..167 give a write; all others are absorbed.
//   cfg_*  : write-only registers (mode, window low, window high), written
//            while no beat is in flight.
//   Path: a write passes the tracker register, then the output register, after
//            its pixel is accepted.
//   Throughput: one pixel per cycle while pixel.ready is high; the tracker counters
//            update in the accepting cycle, so back-to-back beats flow without gaps.
//   Reset: counters wait for a frame start, min/max go to 255/0, the
//            registers to threshold mode with the full window, no write pending.
//   Stall: when result.ready is low a pending write holds; one more beat sits
//            in the tracker, and pixel.ready drops only when that beat is
//            itself a write. Beats giving no write never stall.
`default_nettype none

module camera_crop_decimate_threshold_top #(
    parameter int FRAME_ROWS = ccdt_pkg::FRAME_ROWS_DEF,
    parameter int FRAME_COLS = ccdt_pkg::FRAME_COLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ccdt_pix_if.sink                            pixel,
    ccdt_res_if.source                          result,
    input  wire logic                           cfg_we,
    input  wire logic [ccdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ccdt_pkg::CFG_W-1:0]     cfg_wdata
);

    ccdt_pkg::cfg_t cfg;
    ccdt_pkg::trk_t trk;
    logic           trk_valid;
    logic           trk_ready;

    ccdt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ccdt_track #(
        .FRAME_ROWS (FRAME_ROWS),
        .FRAME_COLS (FRAME_COLS)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .trk_valid (trk_valid),
        .trk       (trk),
        .trk_ready (trk_ready)
    );

    ccdt_proc u_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .trk_valid (trk_valid),
        .trk       (trk),
        .trk_ready (trk_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

/* src/ccdt_checker.sv */
// Port-level checks for the crop/decimate/threshold block, bound to the top level.
// Depends on ccdt_pkg.
`default_nettype none

module ccdt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [ccdt_pkg::ADDR_W-1:0] out_addr,
    input wire logic [ccdt_pkg::PIX_W-1:0]  out_data,
    input wire logic                        out_done
);

    // A stalled write holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_addr) && $stable(out_data))
        else $error("stalled write changed");

    // End of frame only at the last grid position: row 13 is display line 0, column 79
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_done |-> out_addr == 13'd79)
        else $error("frame_done away from last pixel");

    // Writes stay inside the 80x60 picture
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_addr[6:0] <= 7'd79) && (out_addr[12:7] <= 6'd59))
        else $error("write outside picture");

endmodule

bind camera_crop_decimate_threshold_top ccdt_checker u_ccdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_addr  (result.write_addr),
    .out_data  (result.write_data),
    .out_done  (result.frame_done)
);

`default_nettype wire

/* bench/ccdt_write_monitor.sv */
`timescale 1ns / 100ps
// Write monitor for the camera crop, decimate and threshold block: tracks frame position,
// predicts each display write, and compares it with the beats leaving the block.
// Depends on ccdt_pkg and ccdt_if.

module ccdt_write_monitor #(
    parameter int FRAME_ROWS = ccdt_pkg::FRAME_ROWS_DEF,
    parameter int FRAME_COLS = ccdt_pkg::FRAME_COLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ccdt_pix_if                                 pix,
    ccdt_res_if                                 res,
    input  wire logic                           cfg_we,
    input  wire logic [ccdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ccdt_pkg::CFG_W-1:0]     cfg_wdata,
    output int                                  errors,
    output int                                  pending
);
    import ccdt_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
        logic [PIX_W-1:0]  lo;
        logic [PIX_W-1:0]  hi;
        logic              done;
    } disp_write_t;

    // Shadow registers
    logic             thr_mode;
    logic [PIX_W-1:0] win_lo;
    logic [PIX_W-1:0] win_hi;

    // Frame position and brightness tracking
    int               row_pos;
    int               col_pos;
    logic             waiting;
    logic [PIX_W-1:0] lo_seen;
    logic [PIX_W-1:0] hi_seen;

    disp_write_t      due_writes[$];
    disp_write_t      head;

    task automatic report_mismatch(input string what);
        $display("[%0t] write mismatch: %s", $time, what);
        errors++;
    endtask

    // Advance the frame position by one pixel beat and queue the write it causes
    task automatic predict_write(input logic [PIX_W-1:0] p, input logic fs, input logic ls);
        int          r;
        int          c;
        int          a;
        disp_write_t w;
        if (fs)
        begin
            row_pos = FRAME_ROWS - 1;
            col_pos = 0;
            waiting = 1'b0;
            if (thr_mode)
            begin
                lo_seen = PIX_WHITE;
                hi_seen = PIX_BLACK;
            end
        end
        else if (waiting)
            return;
        else if (ls)
        begin
            // line start on the bottom row closes the frame
            if (row_pos == 0)
            begin
                waiting = 1'b1;
                return;
            end
            row_pos--;
            col_pos = 0;
        end

        // columns past the line end are dropped, counter saturates
        if (col_pos >= FRAME_COLS)
            return;
        r = row_pos;
        c = col_pos;
        col_pos++;

        if (!(r > int'(ROW_LO) && r < int'(ROW_HI) && r[0] &&
              c > int'(COL_LO) && c < int'(COL_HI) && c[0]))
            return;

        a = ((r - int'(ROW_BASE)) / 2) * 128 + (c - int'(COL_BASE)) / 2;
        w.addr = a[ADDR_W-1:0];
        if (thr_mode)
        begin
            w.data = (p >= win_lo && p <= win_hi) ? PIX_WHITE : PIX_BLACK;
            if (hi_seen < p)
                hi_seen = p;
            if (lo_seen > p)
                lo_seen = p;
        end
        else
            w.data = p;
        w.lo   = lo_seen;
        w.hi   = hi_seen;
        w.done = (r == int'(LAST_ROW)) && (c == int'(LAST_COL));
        due_writes.push_back(w);
    endtask

    // Outgoing beats are checked before the incoming beat of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_mode = 1'b1;
            win_lo   = PIX_BLACK;
            win_hi   = PIX_WHITE;
            row_pos  = FRAME_ROWS - 1;
            col_pos  = 0;
            waiting  = 1'b1;
            lo_seen  = PIX_WHITE;
            hi_seen  = PIX_BLACK;
            errors   = 0;
            due_writes.delete();
            pending <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (due_writes.size() == 0)
                    report_mismatch($sformatf("write to %0d with none due", res.write_addr));
                else
                begin
                    head = due_writes.pop_front();
                    if (res.write_addr !== head.addr)
                        report_mismatch($sformatf("write_addr %0d, want %0d",
                                                  res.write_addr, head.addr));
                    if (res.write_data !== head.data)
                        report_mismatch($sformatf("write_data %0d at %0d, want %0d",
                                                  res.write_data, head.addr, head.data));
                    if (res.min_level !== head.lo)
                        report_mismatch($sformatf("min_level %0d at %0d, want %0d",
                                                  res.min_level, head.addr, head.lo));
                    if (res.max_level !== head.hi)
                        report_mismatch($sformatf("max_level %0d at %0d, want %0d",
                                                  res.max_level, head.addr, head.hi));
                    if (res.frame_done !== head.done)
                        report_mismatch($sformatf("frame_done %0b at %0d, want %0b",
                                                  res.frame_done, head.addr, head.done));
                end
            end

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE: thr_mode = cfg_wdata[0];
                    CFG_LOW:  win_lo   = cfg_wdata[PIX_W-1:0];
                    CFG_HIGH: win_hi   = cfg_wdata[PIX_W-1:0];
                    default:  ;
                endcase
            end

            if (pix.valid && pix.ready)
                predict_write(pix.pixel_value, pix.frame_start, pix.line_start);

            pending <= due_writes.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench top for camera_crop_decimate_threshold_top: clock, reset, window settings
// and camera pixel stimulus; checking is left to ccdt_write_monitor.
// Depends on ccdt_pkg, ccdt_if, the block and ccdt_write_monitor.

module tb;
    import ccdt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BEATS  = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   cycles = 0;
    int                   errors;
    int                   pending;
    int                   beats_sent;
    int                   rand_base;
    int                   ep;
    logic                 calm;

    ccdt_pix_if pix_ch ();
    ccdt_res_if res_ch ();

    camera_crop_decimate_threshold_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ccdt_write_monitor mon (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // No idling on either side during this stretch
    assign calm = (cycles >= 250) && (cycles < 500);

    // Cycle count and run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL camera_crop_decimate_threshold_top");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pix();
        return PIX_W'($urandom_range(255));
    endfunction

    // One pixel beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [PIX_W-1:0] p, input logic fs, input logic ls);
        while (!calm && $urandom_range(99) < 7)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= p;
        pix_ch.frame_start <= fs;
        pix_ch.line_start  <= ls;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_line(input int extra);
        send_beat(rand_pix(), 1'b0, 1'b1);
        repeat (extra)
            send_beat(rand_pix(), 1'b0, 1'b0);
    endtask

    // Pixels after the line start: mostly short, some reaching the crop, a few past the end
    function automatic int line_extra();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 0;
        else if (pick < 87)
            return $urandom_range(9, 14);
        else if (pick < 97)
            return $urandom_range(15, 40);
        return $urandom_range(166, 185);
    endfunction

    task automatic wait_for_results();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Window settings are loaded only once the block has drained
    task automatic load_window(input logic m, input logic [PIX_W-1:0] lo,
                               input logic [PIX_W-1:0] hi);
        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_wdata <= {{(CFG_W-1){1'b0}}, m};
        @(posedge clk);
        cfg_index <= CFG_LOW;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_index <= CFG_HIGH;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Short frame: skip rows down to the crop, then lines of random length
    task automatic run_frame(input int n_lines);
        send_beat(rand_pix(), 1'b1, ($urandom_range(3) == 0));
        for (int i = 0; i < n_lines; i++)
        begin
            if (i < 11)
                send_line(($urandom_range(9) == 0) ? $urandom_range(12) : 0);
            else
                send_line(line_extra());
        end
    endtask

    // Whole frame down to the last kept pixel, past the bottom row, then ignored beats;
    // the last kept line runs past the line end
    task automatic run_full_frame();
        send_beat(rand_pix(), 1'b1, 1'b0);
        for (int i = 0; i < 143; i++)
        begin
            if (i == 60)
                wait_for_results();
            if (i == 129)
                send_line($urandom_range(176, 182));
            else if (i > 10 && i < 129 && $urandom_range(39) == 0)
                send_line($urandom_range(9, 12));
            else
                send_line(0);
        end
        send_line(0);
        send_beat(rand_pix(), 1'b0, 1'b0);
        send_beat(rand_pix(), 1'b0, 1'b1);
        send_beat(rand_pix(), 1'b0, 1'b0);
    endtask

    // Random flags: stray frame and line starts
    task automatic run_noise(input int n);
        repeat (n)
            send_beat(rand_pix(), ($urandom_range(99) < 6), ($urandom_range(99) < 25));
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_MODE;
        cfg_wdata          = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_value = '0;
        pix_ch.frame_start = 1'b0;
        pix_ch.line_start  = 1'b0;
        res_ch.ready       = 1'b0;
        beats_sent         = 0;

        // Receiver stalls at random
        fork
            forever
            begin
                @(posedge clk);
                res_ch.ready <= calm || ($urandom_range(99) >= 7);
            end
        join_none

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, beat while waiting for a frame, frame and line
        // start together, then the first kept row with both pixel extremes
        send_beat(8'hA5, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        repeat (12)
            send_beat(rand_pix(), 1'b0, 1'b1);
        repeat (8)
            send_beat(rand_pix(), 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(rand_pix(), 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);

        // Random episodes, each under new window settings
        rand_base = beats_sent;
        for (ep = 0; (beats_sent - rand_base) < RANDOM_BEATS || ep < 8; ep++)
        begin
            case (ep)
                0:       load_window(1'b1, 8'h00, 8'hFF);
                1:       load_window(1'b1, 8'd60, 8'd190);
                2:       load_window(1'b0, rand_pix(), rand_pix());
                3:       load_window(1'b1, 8'd200, 8'd40);   // inverted window
                4:       load_window(1'b1, 8'd128, 8'd128);
                5:       load_window(1'b1, 8'hFF, 8'hFF);
                6:       load_window(1'b0, 8'h00, 8'hFF);
                7:       load_window(1'b1, 8'h00, 8'h00);
                default: load_window(1'($urandom_range(1)), rand_pix(), rand_pix());
            endcase

            if (ep == 1)
                run_full_frame();
            else
            begin
                case ($urandom_range(9))
                    0, 1:    run_noise($urandom_range(10, 30));
                    2:       run_frame($urandom_range(1, 11));
                    default: run_frame($urandom_range(12, 13));
                endcase
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (errors == 0)
            $display("PASS camera_crop_decimate_threshold_top");
        else
            $display("FAIL camera_crop_decimate_threshold_top");
        $finish;
    end

endmodule
